// File: rtl/scti_pkg.sv
// Shared constants, widths and the table-building function for the sine/cosine unit.
package scti_pkg;

  localparam int ANGLE_W = 32;
  localparam int PHASE_W = 32;
  localparam int VALUE_W = 16;
  localparam int SLOPE_W = VALUE_W + 1;

  // round(2^32 / (2*pi)), scales radians in Q16.16 to turns
  localparam logic [29:0] INV_TWO_PI_Q32 = 30'd683565276;
  localparam logic [PHASE_W-1:0] QUARTER_TURN = 32'h4000_0000;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned ONE_Q30     = 64'd1073741824;
  localparam longint unsigned SERIES_DIV [7] = '{64'd210, 64'd156, 64'd110, 64'd72,
                                                 64'd42, 64'd20, 64'd6};

  localparam logic signed [VALUE_W-1:0] VALUE_MAX = 16'sh7FFF;
  localparam logic signed [VALUE_W-1:0] VALUE_MIN = 16'sh8000;

  // Q30 angle in [0, pi/2] to Q1.15 sine, odd series through x^15, rounded and saturated
  function automatic logic signed [VALUE_W-1:0] sin_q15(input longint unsigned x,
                                                        input logic neg);
    longint unsigned x2;
    longint unsigned t;
    longint unsigned s;
    longint unsigned mag;
    int i;
    x2 = (x * x) >> 30;
    t  = ONE_Q30;
    for (i = 0; i < 7; i++) begin
      t = ONE_Q30 - ((x2 * t) >> 30) / SERIES_DIV[i];
    end
    s   = (x * t) >> 30;
    mag = (s + 64'd16384) >> 15;
    if (neg) begin
      if (mag >= 64'd32768) return VALUE_MIN;
      return -($signed(VALUE_W'(mag)));
    end
    if (mag >= 64'd32767) return VALUE_MAX;
    return $signed(VALUE_W'(mag));
  endfunction

endpackage

// File: rtl/scti_in_if.sv
// Request channel: command and angle with valid/ready.
interface scti_in_if import scti_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      command;
  logic signed [ANGLE_W-1:0] angle;

  modport source (output valid, output command, output angle, input ready);
  modport sink   (input valid, input command, input angle, output ready);
endinterface

// File: rtl/scti_out_if.sv
// Result channel: interpolated Q1.15 value with valid/ready.
interface scti_out_if import scti_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

// File: rtl/scti_phase.sv
// Front pipeline: radians to turns, cosine offset, table index and weight.
module scti_phase
  import scti_pkg::*;
#(
  parameter int TABLE_DEPTH = 1024,
  parameter int FRAC_BITS   = 16,
  localparam int IDX_W      = $clog2(TABLE_DEPTH)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      feed_valid,
  output logic                      feed_ready,
  input  logic                      command,
  input  logic signed [ANGLE_W-1:0] angle,
  output logic                      done_valid,
  input  logic                      done_ready,
  output logic [IDX_W-1:0]          idx,
  output logic [FRAC_BITS-1:0]      weight
);

  localparam int DEPTH_W = $clog2(TABLE_DEPTH + 1);
  localparam int Q_W     = PHASE_W + DEPTH_W;
  localparam int PROD_W  = ANGLE_W + 31;
  localparam logic [DEPTH_W-1:0] DEPTH_C = DEPTH_W'(TABLE_DEPTH);

  logic                     v1, v2, v3;
  logic                     en1, en2, en3;
  logic signed [PROD_W-1:0] prod1;
  logic                     cmd1;
  logic [PHASE_W-1:0]       phase2;
  logic [Q_W-1:0]           q;

  assign en3 = !v3 || done_ready;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;

  assign feed_ready = en1;
  assign done_valid = v3;

  assign q = {{DEPTH_W{1'b0}}, phase2} * {{PHASE_W{1'b0}}, DEPTH_C};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) v1 <= feed_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
    end
    if (en1) begin
      prod1 <= angle * $signed({1'b0, INV_TWO_PI_Q32});
      cmd1  <= command;
    end
    if (en2) begin
      phase2 <= prod1[PHASE_W+15:16] + (cmd1 ? QUARTER_TURN : '0);
    end
    if (en3) begin
      idx    <= q[PHASE_W +: IDX_W];
      weight <= q[PHASE_W-1 -: FRAC_BITS];
    end
  end

endmodule

// File: rtl/scti_rom.sv
// Sine table of one period: entry and slope to the next entry, registered read.
module scti_rom
  import scti_pkg::*;
#(
  parameter int TABLE_DEPTH = 1024,
  localparam int IDX_W      = $clog2(TABLE_DEPTH)
) (
  input  logic                      clk,
  input  logic                      rd_en,
  input  logic [IDX_W-1:0]          addr,
  output logic signed [VALUE_W-1:0] base,
  output logic signed [SLOPE_W-1:0] delta
);

  logic signed [VALUE_W-1:0] entry [TABLE_DEPTH];
  logic signed [SLOPE_W-1:0] slope [TABLE_DEPTH];

  for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_entry
    localparam longint unsigned M    = longint'(k) * 4;
    localparam longint unsigned QUAD = M / TABLE_DEPTH;
    localparam longint unsigned REM  = M - QUAD * TABLE_DEPTH;
    localparam longint unsigned R    = (QUAD % 2 == 1) ? (TABLE_DEPTH - REM) : REM;
    localparam longint unsigned X    = (HALF_PI_Q30 * R + TABLE_DEPTH / 2) / TABLE_DEPTH;
    assign entry[k] = sin_q15(X, ((QUAD / 2) % 2) == 1);
  end

  // last entry wraps to entry 0
  for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_slope
    assign slope[k] = SLOPE_W'(entry[(k + 1) % TABLE_DEPTH]) - SLOPE_W'(entry[k]);
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      base  <= entry[addr];
      delta <= slope[addr];
    end
  end

endmodule

// File: rtl/scti_interp.sv
// Back pipeline: table read, linear blend with rounding, saturation.
module scti_interp
  import scti_pkg::*;
#(
  parameter int TABLE_DEPTH = 1024,
  parameter int FRAC_BITS   = 16,
  localparam int IDX_W      = $clog2(TABLE_DEPTH)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      feed_valid,
  output logic                      feed_ready,
  input  logic [IDX_W-1:0]          idx,
  input  logic [FRAC_BITS-1:0]      weight,
  output logic                      done_valid,
  input  logic                      done_ready,
  output logic signed [VALUE_W-1:0] value
);

  localparam int MUL_W = SLOPE_W + FRAC_BITS + 1;
  localparam int ACC_W = FRAC_BITS + 19;
  localparam logic signed [ACC_W-1:0] ROUND_C = ACC_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'(VALUE_MAX);
  localparam logic signed [ACC_W-1:0] ACC_MIN = ACC_W'(VALUE_MIN);

  logic                      v4, v5, v6;
  logic                      en4, en5, en6;
  logic signed [VALUE_W-1:0] base4;
  logic signed [SLOPE_W-1:0] delta4;
  logic [FRAC_BITS-1:0]      w4;
  logic signed [MUL_W-1:0]   prod;
  logic signed [ACC_W-1:0]   acc5;
  logic signed [ACC_W-1:0]   shifted;
  logic signed [VALUE_W-1:0] value_next;

  assign en6 = !v6 || done_ready;
  assign en5 = !v5 || en6;
  assign en4 = !v4 || en5;

  assign feed_ready = en4;
  assign done_valid = v6;

  scti_rom #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_rom (
    .clk  (clk),
    .rd_en(en4),
    .addr (idx),
    .base (base4),
    .delta(delta4)
  );

  assign prod    = delta4 * $signed({1'b0, w4});
  assign shifted = acc5 >>> FRAC_BITS;

  always_comb begin
    priority if (shifted > ACC_MAX) value_next = VALUE_MAX;
    else if (shifted < ACC_MIN)     value_next = VALUE_MIN;
    else                            value_next = shifted[VALUE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else begin
      if (en4) v4 <= feed_valid;
      if (en5) v5 <= v4;
      if (en6) v6 <= v5;
    end
    if (en4) w4 <= weight;
    if (en5) acc5 <= (ACC_W'(base4) <<< FRAC_BITS) + ACC_W'(prod) + ROUND_C;
    if (en6) value <= value_next;
  end

endmodule

// File: rtl/sine_cosine_table_interp.sv
// Top level: table sine/cosine with linear interpolation, six-stage pipeline.
//
//   channel   role    beat
//   operand   sink    command (1 = cosine), angle (Q16.16 radians)
//   result    source  value (Q1.15, saturated)
//
// One beat per cycle sustained while the result side is ready; each beat passes
// through the stages in order. The stages: angle multiply, phase and quarter-turn offset, index multiply,
// table read, blend, saturate. Each stage holds its own valid bit and moves
// when the one after it is free, so bubbles close up under backpressure.
// Reset clears the valid bits only.
module sine_cosine_table_interp
  import scti_pkg::*;
#(
  parameter int TABLE_DEPTH = 1024,
  parameter int FRAC_BITS   = 16
) (
  input logic               clk,
  input logic               rst,
  scti_in_if.sink           operand,
  scti_out_if.source        result
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);

  logic                 mid_valid;
  logic                 mid_ready;
  logic [IDX_W-1:0]     mid_idx;
  logic [FRAC_BITS-1:0] mid_weight;

  scti_phase #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_phase (
    .clk       (clk),
    .rst       (rst),
    .feed_valid(operand.valid),
    .feed_ready(operand.ready),
    .command   (operand.command),
    .angle     (operand.angle),
    .done_valid(mid_valid),
    .done_ready(mid_ready),
    .idx       (mid_idx),
    .weight    (mid_weight)
  );

  scti_interp #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_interp (
    .clk       (clk),
    .rst       (rst),
    .feed_valid(mid_valid),
    .feed_ready(mid_ready),
    .idx       (mid_idx),
    .weight    (mid_weight),
    .done_valid(result.valid),
    .done_ready(result.ready),
    .value     (result.value)
  );

  logic taken;
  logic flow;

  assign taken = operand.valid && operand.ready && !rst;
  assign flow  = result.ready && !rst;

  // a free output stage means the whole pipe can take a beat
  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    (!result.valid || result.ready) |-> operand.ready)
    else $error("operand stalled with output stage free");

  a_reset_empties: assert property (@(posedge clk)
    rst |=> !result.valid)
    else $error("result valid right after reset");

  // with the sink always ready a beat that went in comes out after passing every stage
  a_latency: assert property (@(posedge clk) disable iff (rst)
    ($past(taken, 6) && $past(flow, 5) && $past(flow, 4) && $past(flow, 3)
     && $past(flow, 2) && $past(flow, 1)) |-> result.valid)
    else $error("beat lost in pipeline");

endmodule
